>>> rtl/gdd_pkg.sv
package gdd_pkg;

    localparam int unsigned DAY_W    = 5;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned DAYS_W   = 22;
    localparam int unsigned ORDER_W  = 2;
    // Day serial: 365 * 16383 plus leap days, month offset and day fits in 23 bits
    localparam int unsigned SERIAL_W = 23;

    localparam logic [ORDER_W-1:0] ORDER_EQUAL = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_FIRST = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_LATER = 2'd2;

    localparam logic [DAYS_W-1:0] DAYS_MAX = {DAYS_W{1'b1}};

    typedef struct packed {
        logic [DAY_W-1:0]   first_day;
        logic [MONTH_W-1:0] first_month;
        logic [YEAR_W-1:0]  first_year;
        logic [DAY_W-1:0]   second_day;
        logic [MONTH_W-1:0] second_month;
        logic [YEAR_W-1:0]  second_year;
    } t_gdd_in;

    typedef struct packed {
        logic [DAYS_W-1:0]  days_apart;
        logic [ORDER_W-1:0] date_order;
    } t_gdd_out;

    // Days in the months before month m of a common year; 13..15 keep adding 31.
    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            4'd13:   d = 9'd365;
            4'd14:   d = 9'd396;
            4'd15:   d = 9'd427;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // floor(x / 100) by reciprocal 5243 / 2^19; exact for x below 43690.
    function automatic logic [8:0] div100(input logic [14:0] x);
        logic [27:0] p;
        p = 28'(x) * 28'd5243;
        return p[27:19];
    endfunction

endpackage

>>> rtl/gdd_serial.sv
module gdd_serial (
    input  logic [gdd_pkg::DAY_W-1:0]    i_day,
    input  logic [gdd_pkg::MONTH_W-1:0]  i_month,
    input  logic [gdd_pkg::YEAR_W-1:0]   i_year,
    output logic [gdd_pkg::SERIAL_W-1:0] o_serial
);
    import gdd_pkg::*;

    logic [14:0] y_ext;
    logic [14:0] y_p3;
    logic [14:0] y_p99;
    logic [14:0] y_p399;
    logic [12:0] ceil4;
    logic [8:0]  ceil100;
    logic [8:0]  floor100;
    logic [8:0]  ceil400;
    logic [8:0]  floor400;
    logic [12:0] leaps;
    logic        is_leap;
    logic        leap_day;

    assign y_ext  = 15'(i_year);
    assign y_p3   = y_ext + 15'd3;
    assign y_p99  = y_ext + 15'd99;
    assign y_p399 = y_ext + 15'd399;

    // Ceiling and floor quotients run side by side; they differ unless the year divides
    assign ceil4    = y_p3[14:2];
    assign ceil100  = div100(y_p99);
    assign floor100 = div100(y_ext);
    assign ceil400  = div100({2'b00, y_p399[14:2]});
    assign floor400 = div100({2'b00, y_ext[14:2]});

    // Leap years among 0 .. year-1
    assign leaps = ceil4 - 13'(ceil100) + 13'(ceil400);

    assign is_leap  = (i_year[1:0] == 2'b00) &&
                      ((ceil100 != floor100) || (ceil400 == floor400));
    assign leap_day = is_leap && (i_month >= 4'd3);

    assign o_serial = SERIAL_W'(i_year) * SERIAL_W'(365)
                    + SERIAL_W'(leaps)
                    + SERIAL_W'(days_before_month(i_month))
                    + SERIAL_W'(leap_day)
                    + SERIAL_W'(i_day);

endmodule

>>> rtl/gregorian_day_difference_core.sv
// Day count between two Gregorian dates. Each item carries two dates (day,
// month, year); the result gives the absolute number of days between them,
// saturated at 4194303, and their order (equal, first earlier, first later),
// where order compares year, then month, then day as plain numbers. Day and
// month are not range checked: odd values simply add to each date's serial,
// so the order code may then disagree with the day count. The block takes one
// item per clock unless o_in_stall is high; each item moves through one input
// register, one pass of closed-form day counting with constant reciprocal
// divisions and one result register. Both sides use valid/stall; an
// item is taken while a finished result still waits, and o_in_stall only
// rises when both registers are full and the result is being held off.
module gregorian_day_difference_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  gdd_pkg::t_gdd_in  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output gdd_pkg::t_gdd_out o_out_item
);
    import gdd_pkg::*;

    // Input stage
    logic     r_in_vld;
    logic     n_in_vld;
    t_gdd_in  r_in_item;

    // Result stage
    logic     r_out_vld;
    logic     n_out_vld;
    t_gdd_out r_out_item;
    t_gdd_out n_out_item;

    logic     out_adv;
    logic     in_adv;

    logic [SERIAL_W-1:0] serial_first;
    logic [SERIAL_W-1:0] serial_second;
    logic [SERIAL_W-1:0] serial_diff;
    logic [22:0]         key_first;
    logic [22:0]         key_second;

    // Result register frees when empty or drained; input register frees when it can move on
    assign out_adv    = !r_out_vld || !i_out_stall;
    assign in_adv     = !r_in_vld || out_adv;
    assign o_in_stall = !in_adv;

    assign n_in_vld  = in_adv ? i_in_valid : r_in_vld;
    assign n_out_vld = out_adv ? r_in_vld : r_out_vld;

    gdd_serial u_serial_first (
        .i_day    (r_in_item.first_day),
        .i_month  (r_in_item.first_month),
        .i_year   (r_in_item.first_year),
        .o_serial (serial_first)
    );

    gdd_serial u_serial_second (
        .i_day    (r_in_item.second_day),
        .i_month  (r_in_item.second_month),
        .i_year   (r_in_item.second_year),
        .o_serial (serial_second)
    );

    // Year, month, day concatenated compare in lexicographic order
    assign key_first  = {r_in_item.first_year, r_in_item.first_month, r_in_item.first_day};
    assign key_second = {r_in_item.second_year, r_in_item.second_month,
                         r_in_item.second_day};

    assign serial_diff = (serial_first >= serial_second) ? (serial_first - serial_second)
                                                         : (serial_second - serial_first);

    always_comb begin
        // Saturate anything past 22 bits
        if (serial_diff[SERIAL_W-1]) begin
            n_out_item.days_apart = DAYS_MAX;
        end else begin
            n_out_item.days_apart = serial_diff[DAYS_W-1:0];
        end

        if (key_first == key_second) begin
            n_out_item.date_order = ORDER_EQUAL;
        end else if (key_first < key_second) begin
            n_out_item.date_order = ORDER_FIRST;
        end else begin
            n_out_item.date_order = ORDER_LATER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload: load on advance, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_in_item <= i_in_item;
        end
        if (out_adv) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

>>> rtl/gdd_check.sv
module gdd_check (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input gdd_pkg::t_gdd_in  i_in_item,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input gdd_pkg::t_gdd_out o_out_item
);
    import gdd_pkg::*;

    // Input only backs up when a result is both waiting and held off
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // Equal dates give zero days
    a_equal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.date_order == ORDER_EQUAL))
            |-> (o_out_item.days_apart == '0))
        else $error("equal dates with nonzero day count");

    // Nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // Held result stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result dropped or changed");

endmodule

bind gregorian_day_difference_core gdd_check u_gdd_check (.*);

>>> dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gdd_pkg::*;

    // Random part size; together with the directed rows this gives about 1600 date pairs
    localparam int unsigned RANDOM_PAIRS = 1578;
    // Last stretch of the run with no gaps on either side
    localparam int unsigned STEADY_TAIL  = 200;
    // Receiver hold-off, long enough to fill both stages and back up the input
    localparam int unsigned LONG_HOLD    = 120;
    // Count of pairs sent that triggers the long hold-off
    localparam int unsigned HOLD_AT      = 400;
    // Settling wait after the last span, before the final verdict
    localparam int unsigned SETTLE       = 8;
    // Cycles with no item moving on either side before the run is declared hung
    localparam int unsigned HANG_LIMIT   = 2000;

    // Days before month m of a common year; months 13..15 keep adding 31
    localparam int unsigned MONTH_START [0:15] = '{
        0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365, 396, 427
    };

    typedef struct packed {
        t_gdd_in  pair;
        logic     typed;    // 1: the span below is known by hand
        t_gdd_out want;
    } t_span_case;

    localparam int unsigned N_CASES = 22;
    localparam t_span_case SPAN_CASES [0:N_CASES-1] = '{
        // same date twice
        '{'{5'd1, 4'd1, 14'd2000, 5'd1, 4'd1, 14'd2000}, 1'b1, '{22'd0, ORDER_EQUAL}},
        // year zero is a leap year
        '{'{5'd1, 4'd1, 14'd0, 5'd1, 4'd1, 14'd1}, 1'b1, '{22'd366, ORDER_FIRST}},
        // all-zero fields against all-ones fields: saturate both ways
        '{'{5'd0, 4'd0, 14'd0, 5'd31, 4'd15, 14'd16383}, 1'b1, '{DAYS_MAX, ORDER_FIRST}},
        '{'{5'd31, 4'd15, 14'd16383, 5'd0, 4'd0, 14'd0}, 1'b1, '{DAYS_MAX, ORDER_LATER}},
        // across February in a 400-year leap, a century common year, another 400-year leap
        '{'{5'd1, 4'd3, 14'd2000, 5'd28, 4'd2, 14'd2000}, 1'b1, '{22'd2, ORDER_LATER}},
        '{'{5'd1, 4'd3, 14'd1900, 5'd28, 4'd2, 14'd1900}, 1'b1, '{22'd1, ORDER_LATER}},
        '{'{5'd1, 4'd3, 14'd2400, 5'd28, 4'd2, 14'd2400}, 1'b1, '{22'd2, ORDER_LATER}},
        // month zero acts like January, yet orders before it
        '{'{5'd5, 4'd0, 14'd2023, 5'd5, 4'd1, 14'd2023}, 1'b1, '{22'd0, ORDER_FIRST}},
        // day zero of March lands on the last of February
        '{'{5'd0, 4'd3, 14'd2001, 5'd28, 4'd2, 14'd2001}, 1'b1, '{22'd0, ORDER_LATER}},
        // month 13 lands on January of the next year
        '{'{5'd1, 4'd13, 14'd2001, 5'd1, 4'd1, 14'd2002}, 1'b1, '{22'd0, ORDER_FIRST}},
        // April 31st lands on May 1st
        '{'{5'd31, 4'd4, 14'd2021, 5'd1, 4'd5, 14'd2021}, 1'b1, '{22'd0, ORDER_FIRST}},
        // year past 9999 still uses the same formula
        '{'{5'd1, 4'd1, 14'd10000, 5'd1, 4'd1, 14'd9999}, 1'b1, '{22'd365, ORDER_LATER}},
        // year boundary
        '{'{5'd31, 4'd12, 14'd1999, 5'd1, 4'd1, 14'd2000}, 1'b1, '{22'd1, ORDER_FIRST}},
        '{'{5'd31, 4'd15, 14'd0, 5'd0, 4'd15, 14'd0}, 1'b1, '{22'd31, ORDER_LATER}},
        // the rest go through the predictor
        '{'{5'd31, 4'd12, 14'd9999, 5'd1, 4'd1, 14'd0}, 1'b0, '0},
        '{'{5'd1, 4'd1, 14'd0, 5'd31, 4'd12, 14'd9999}, 1'b0, '0},
        '{'{5'd31, 4'd15, 14'd9999, 5'd1, 4'd14, 14'd9999}, 1'b0, '0},
        '{'{5'd29, 4'd2, 14'd2024, 5'd1, 4'd3, 14'd2023}, 1'b0, '0},
        '{'{5'd1, 4'd1, 14'd16383, 5'd1, 4'd1, 14'd4000}, 1'b0, '0},
        '{'{5'd15, 4'd6, 14'd1987, 5'd4, 4'd11, 14'd2031}, 1'b0, '0},
        '{'{5'd16, 4'd8, 14'd8191, 5'd16, 4'd8, 14'd8192}, 1'b0, '0},
        '{'{5'd1, 4'd1, 14'd0, 5'd0, 4'd0, 14'd1}, 1'b0, '0}
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_gdd_in   i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_gdd_out  o_out_item;

    // Spans still owed by the block, oldest first
    t_gdd_out  spans_due [$];

    int unsigned pairs_sent;
    int unsigned spans_checked;
    int unsigned mismatches;
    int unsigned hang_count;
    int unsigned equal_seen, earlier_seen, later_seen, saturated_seen;
    bit          steady_tail;
    bit          held_off;

    wire pair_taken = i_in_valid && !o_in_stall;
    wire span_taken = o_out_valid && !i_out_stall;

    always #5 i_clk = ~i_clk;

    gregorian_day_difference_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------

    function automatic bit is_leap_year(input longint y);
        if (y % 400 == 0) begin
            return 1'b1;
        end
        if (y % 100 == 0) begin
            return 1'b0;
        end
        return (y % 4 == 0);
    endfunction

    // Day number counted from year zero: whole years, leap days before the year,
    // months before this one, then the day itself
    function automatic longint day_number(input logic [4:0] d, input logic [3:0] m,
                                          input logic [13:0] y);
        longint yy;
        longint n;
        yy = longint'(y);
        n  = 365 * yy + (yy + 3) / 4 - (yy + 99) / 100 + (yy + 399) / 400;
        n  = n + longint'(MONTH_START[m]);
        if (m >= 4'd3 && is_leap_year(yy)) begin
            n = n + 1;
        end
        return n + longint'(d);
    endfunction

    function automatic t_gdd_out date_span(input t_gdd_in p);
        longint   n1, n2, gap;
        t_gdd_out r;
        n1  = day_number(p.first_day, p.first_month, p.first_year);
        n2  = day_number(p.second_day, p.second_month, p.second_year);
        gap = (n1 >= n2) ? n1 - n2 : n2 - n1;
        r.days_apart = (gap > longint'(DAYS_MAX)) ? DAYS_MAX : 22'(gap);
        // Order compares the raw fields, not the day numbers
        if (p.first_year != p.second_year) begin
            r.date_order = (p.first_year < p.second_year) ? ORDER_FIRST : ORDER_LATER;
        end else if (p.first_month != p.second_month) begin
            r.date_order = (p.first_month < p.second_month) ? ORDER_FIRST : ORDER_LATER;
        end else if (p.first_day != p.second_day) begin
            r.date_order = (p.first_day < p.second_day) ? ORDER_FIRST : ORDER_LATER;
        end else begin
            r.date_order = ORDER_EQUAL;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random date pairs
    // ------------------------------------------------------------------

    function automatic logic [4:0] month_length(input logic [3:0] m, input logic [13:0] y);
        case (m)
            4'd2:                      return is_leap_year(longint'(y)) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   return 5'd30;
            default:                   return 5'd31;
        endcase
    endfunction

    // Mostly real calendar dates, often close together so that order and
    // leap-day handling get exercised; the rest is raw noise over every field bit
    function automatic t_gdd_in random_pair();
        t_gdd_in     p;
        int unsigned kind;
        kind = $urandom_range(0, 99);
        p.first_year   = 14'($urandom_range(0, 9999));
        p.first_month  = 4'($urandom_range(1, 12));
        p.first_day    = 5'($urandom_range(1, month_length(p.first_month, p.first_year)));
        p.second_year  = 14'($urandom_range(0, 9999));
        p.second_month = 4'($urandom_range(1, 12));
        p.second_day   = 5'($urandom_range(1, month_length(p.second_month, p.second_year)));
        if (kind < 10) begin
            // identical dates
            p.second_year  = p.first_year;
            p.second_month = p.first_month;
            p.second_day   = p.first_day;
        end else if (kind < 30) begin
            // same year, possibly same month
            p.second_year = p.first_year;
            if (kind < 18) begin
                p.second_month = p.first_month;
            end
            if (p.second_day > month_length(p.second_month, p.second_year)) begin
                p.second_day = month_length(p.second_month, p.second_year);
            end
        end else if (kind < 45) begin
            // neighboring year, first date on the last day of its month
            p.second_year = (p.first_year == 14'd9999) ? 14'd9998 : p.first_year + 14'd1;
            p.first_day   = month_length(p.first_month, p.first_year);
            if (p.second_day > month_length(p.second_month, p.second_year)) begin
                p.second_day = month_length(p.second_month, p.second_year);
            end
        end else if (kind >= 85) begin
            // raw noise: any day, month and year the fields can hold
            p.first_day    = 5'($urandom());
            p.first_month  = 4'($urandom());
            p.first_year   = 14'($urandom());
            p.second_day   = 5'($urandom());
            p.second_month = 4'($urandom());
            p.second_year  = 14'($urandom());
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Present one pair and hold it until the block takes it, then log what it owes
    task automatic offer_pair(input t_gdd_in p, input t_gdd_out want);
        i_in_valid <= 1'b1;
        i_in_item  <= p;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        spans_due.push_back(want);
        pairs_sent++;
    endtask

    // Drop valid for a random burst, but only when gaps are enabled
    task automatic sender_gap(input int unsigned gap_pct);
        if (!steady_tail && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    initial begin
        int unsigned gap_pct;
        t_gdd_in     p;
        t_gdd_out    want;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;

        // Hold reset, then release it on an edge
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: hand-known spans where given, predictor otherwise
        for (int unsigned k = 0; k < N_CASES; k++) begin
            want = SPAN_CASES[k].typed ? SPAN_CASES[k].want : date_span(SPAN_CASES[k].pair);
            offer_pair(SPAN_CASES[k].pair, want);
            sender_gap(25);
        end

        gap_pct = 0;
        for (int unsigned k = 0; k < RANDOM_PAIRS; k++) begin
            // Pick gappy or gap-free stretches at random
            if (k % 64 == 0) begin
                gap_pct = ($urandom_range(0, 1) == 1) ? 30 : 0;
            end
            if (k == RANDOM_PAIRS - STEADY_TAIL) begin
                steady_tail = 1'b1;
            end
            // Once, halfway in, pause until the block has handed back everything
            if (k == RANDOM_PAIRS / 2) begin
                i_in_valid <= 1'b0;
                while (spans_due.size() != 0) begin
                    @(posedge i_clk);
                end
            end
            p = random_pair();
            offer_pair(p, date_span(p));
            sender_gap(gap_pct);
        end
        i_in_valid <= 1'b0;

        // Wait out the remaining spans, then a settling wait for stray results
        while (spans_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);

        if (spans_due.size() != 0) begin
            $error("%0d spans still owed at end of run", spans_due.size());
            mismatches++;
        end
        $display("Covered %0d date pairs (%0d directed), %0d spans checked, %0d saturated.",
                 pairs_sent, N_CASES, spans_checked, saturated_seen);
        $display("Order codes seen: %0d equal, %0d first earlier, %0d first later.",
                 equal_seen, earlier_seen, later_seen);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off, none in the tail
    // ------------------------------------------------------------------

    initial begin
        i_out_stall = 1'b0;
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            if (steady_tail) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if (!held_off && pairs_sent >= HOLD_AT) begin
                // Hold off long enough for the block to back up its input
                held_off = 1'b1;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: each accepted span against the oldest one owed
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_gdd_out want;
        if (i_rst_n && span_taken) begin
            if (spans_due.size() == 0) begin
                $error("span %0d / order %0d arrived with nothing owed",
                       o_out_item.days_apart, o_out_item.date_order);
                mismatches++;
            end else begin
                want = spans_due.pop_front();
                spans_checked++;
                if (o_out_item.days_apart !== want.days_apart) begin
                    $error("days_apart: expected %0d, got %0d",
                           want.days_apart, o_out_item.days_apart);
                    mismatches++;
                end
                if (o_out_item.date_order !== want.date_order) begin
                    $error("date_order: expected %0d, got %0d",
                           want.date_order, o_out_item.date_order);
                    mismatches++;
                end
                case (want.date_order)
                    ORDER_EQUAL: equal_seen++;
                    ORDER_FIRST: earlier_seen++;
                    default:     later_seen++;
                endcase
                if (want.days_apart == DAYS_MAX) begin
                    saturated_seen++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Hang detection: count cycles in which no item moves on either side
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (pair_taken || span_taken) begin
            hang_count <= 0;
        end else begin
            hang_count <= hang_count + 1;
        end
        if (hang_count >= HANG_LIMIT) begin
            $display("Timed out: no item moved for %0d cycles, %0d spans owed",
                     HANG_LIMIT, spans_due.size());
            $display("tb NOT OK");
            $finish;
        end
    end

endmodule

>>> sim.f
rtl/gdd_pkg.sv
rtl/gdd_serial.sv
rtl/gregorian_day_difference_core.sv
rtl/gdd_check.sv
dv/tb.sv
